// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SET_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("sorted_event_table: assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define SET_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("sorted_event_table: assertion failed");

`endif

// ===== design/set_pkg.sv =====
// Shared types, constants and codes of the sorted event table.
package set_pkg;

    localparam int MAX_EVENTS        = 256;
    localparam int ROW_COUNT         = 128;
    localparam int TICKS_PER_QUARTER = 96;

    localparam int AW      = $clog2(MAX_EVENTS);
    localparam int CW      = $clog2(MAX_EVENTS + 1);
    localparam int PLEN_W  = $clog2(TICKS_PER_QUARTER * 4 * 32 * 64 + 1);
    localparam int TICK_W  = 19;
    localparam int ROW_W   = 8;
    localparam int VEL_W   = 7;
    localparam int CHN_W   = 7;
    localparam int LEN_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam int VEL_MAX   = 127;
    localparam int CHN_MAX   = 100;
    localparam int BEATS_MAX = 32;
    localparam int BARS_MAX  = 64;

    typedef enum logic [2:0] {
        K_ADD    = 3'd0,
        K_REMOVE = 3'd1,
        K_MOVE   = 3'd2,
        K_UPDATE = 3'd3,
        K_FIND   = 3'd4,
        K_READ   = 3'd5,
        K_CLEAR  = 3'd6,
        K_TRIM   = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FULL      = 3'd3,
        ST_TAKEN     = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEATS = 2'd0,
        CFG_UNIT  = 2'd1,
        CFG_BARS  = 2'd2,
        CFG_NONE  = 2'd3
    } t_cfg_idx;

    // One stored event, 57 bits
    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic [ROW_W-1:0]  row;
        logic [VEL_W-1:0]  vel;
        logic [CHN_W-1:0]  chance;
        logic [LEN_W-1:0]  len;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic    ld_in;
        logic    init_src;
        logic    init_tgt;
        logic    srch_rd;
        logic    srch_cmp;
        logic    rd_lo;
        logic    rd_slot;
        logic    cap;
        logic    save_src;
        logic    sh_up;
        logic    sh_dn;
        logic    sh_trim;
        logic    sh_run;
        logic    wr_new;
        logic    wr_hold;
        logic    wr_upd;
        logic    used_inc;
        logic    used_dec;
        logic    used_clr;
        logic    used_trim;
        logic    set_active;
        logic    done;
        logic    show;
        t_status status;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_kind kind;
        logic  lt;
        logic  found;
        logic  in_range;
        logic  full;
        logic  sh_busy;
        logic  slot_ok;
        logic  same_key;
    } t_stat;

endpackage

// ===== design/set_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module set_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/set_dpath.sv =====
// Datapath: event RAM, search bounds, shift engine, config and result registers.
module set_dpath import set_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [2:0]            i_kind,
    input  logic [ROW_W-1:0]      i_row,
    input  logic [TICK_W-1:0]     i_tick,
    input  logic [ROW_W-1:0]      i_target_row,
    input  logic [TICK_W-1:0]     i_target_tick,
    input  logic [7:0]            i_note_velocity,
    input  logic [7:0]            i_chance,
    input  logic [LEN_W-1:0]      i_length_ticks,
    input  logic [AW-1:0]         i_slot,
    output logic                  o_valid,
    output logic [2:0]            o_status,
    output logic [AW-1:0]         o_found_slot,
    output logic [ROW_W-1:0]      o_event_row,
    output logic [TICK_W-1:0]     o_event_tick,
    output logic [VEL_W-1:0]      o_event_velocity,
    output logic [CHN_W-1:0]      o_event_chance,
    output logic [LEN_W-1:0]      o_event_length,
    output logic [CW-1:0]         o_entry_count,
    output logic                  o_pattern_active
);

    typedef enum logic [1:0] {
        M_UP   = 2'd0,
        M_DN   = 2'd1,
        M_TRIM = 2'd2
    } t_mode;

    // latched item
    t_kind             r_kind;
    logic [ROW_W-1:0]  r_row, r_trow;
    logic [TICK_W-1:0] r_tick, r_ttick;
    logic [VEL_W-1:0]  r_vel;
    logic [CHN_W-1:0]  r_chance;
    logic [LEN_W-1:0]  r_len;
    logic [AW-1:0]     r_slot;

    // search and table state
    logic [ROW_W-1:0]  r_key_row;
    logic [TICK_W-1:0] r_key_tick;
    logic [CW-1:0]     r_lo, r_hi, r_pos, r_src, r_used;
    logic              r_found, r_active;
    t_entry            r_ev, r_hold;

    // shift engine
    logic [CW-1:0]     r_idx, r_wa;
    logic              r_more, r_pend;
    t_mode             r_mode;

    // config and pattern length
    logic [5:0]        r_beats;
    logic [4:0]        r_unit;
    logic [6:0]        r_bars;
    logic [PLEN_W-1:0] r_base, r_plen;

    logic [CW:0]       mid_sum;
    logic [CW-1:0]     mid;
    t_entry            rd_data, wdata, new_e, upd_e;
    logic [AW-1:0]     waddr, raddr;
    logic              we, keep, less;
    logic [5:0]        num;
    logic [6:0]        bars;
    logic [2:0]        den_sh;
    logic [PLEN_W-1:0] prod;

    set_ram #(.WIDTH($bits(t_entry)), .DEPTH(MAX_EVENTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // midpoint and key compare
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign less    = {rd_data.tick, rd_data.row} < {r_key_tick, r_key_row};
    assign keep    = {1'b0, rd_data.tick} < r_plen;

    // entries to be written
    always_comb begin
        new_e      = '0;
        new_e.tick = r_key_tick;
        new_e.row  = r_key_row;
        if (i_cmd.wr_hold) begin
            new_e.vel    = r_hold.vel;
            new_e.chance = r_hold.chance;
            new_e.len    = r_hold.len;
        end else begin
            new_e.vel    = r_vel;
            new_e.chance = r_chance;
            new_e.len    = r_len;
        end
        upd_e        = r_ev;
        upd_e.vel    = r_vel;
        upd_e.chance = r_chance;
        upd_e.len    = r_len;
    end

    // RAM port selection
    always_comb begin
        we    = 1'b0;
        waddr = r_wa[AW-1:0];
        wdata = rd_data;
        if (i_cmd.sh_run && r_pend && (r_mode != M_TRIM || keep)) begin
            we = 1'b1;
        end else if (i_cmd.wr_new) begin
            we    = 1'b1;
            waddr = r_lo[AW-1:0];
            wdata = new_e;
        end else if (i_cmd.wr_upd) begin
            we    = 1'b1;
            waddr = r_pos[AW-1:0];
            wdata = upd_e;
        end
        priority if (i_cmd.srch_rd) begin
            raddr = mid[AW-1:0];
        end else if (i_cmd.rd_lo) begin
            raddr = r_lo[AW-1:0];
        end else if (i_cmd.rd_slot) begin
            raddr = r_slot;
        end else begin
            raddr = r_idx[AW-1:0];
        end
    end

    // pattern length terms
    always_comb begin
        num  = (r_beats == '0) ? 6'd1 : (r_beats > 6'(BEATS_MAX)) ? 6'(BEATS_MAX) : r_beats;
        bars = (r_bars == '0) ? 7'd1 : (r_bars > 7'(BARS_MAX)) ? 7'(BARS_MAX) : r_bars;
        unique case (r_unit)
            5'd2:    den_sh = 3'd1;
            5'd8:    den_sh = 3'd3;
            5'd16:   den_sh = 3'd4;
            default: den_sh = 3'd2;
        endcase
        prod = PLEN_W'(r_base * PLEN_W'(bars));
    end

    // status to controller
    always_comb begin
        o_stat.kind     = r_kind;
        o_stat.lt       = r_lo < r_hi;
        o_stat.found    = r_found;
        o_stat.in_range = (int'(r_key_row) < ROW_COUNT) && ({1'b0, r_key_tick} < r_plen);
        o_stat.full     = r_used == CW'(MAX_EVENTS);
        o_stat.sh_busy  = r_more | r_pend;
        o_stat.slot_ok  = {1'b0, r_slot} < r_used;
        o_stat.same_key = (r_trow == r_row) && (r_ttick == r_tick);
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beats <= 6'd4;
            r_unit  <= 5'd4;
            r_bars  <= 7'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BEATS: r_beats <= i_cfg_data[5:0];
                CFG_UNIT:  r_unit  <= i_cfg_data[4:0];
                CFG_BARS:  r_bars  <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // pattern length, two registered steps
    always_ff @(posedge i_clk) begin
        r_base <= PLEN_W'(PLEN_W'(num) * PLEN_W'(TICKS_PER_QUARTER * 4)) >> den_sh;
        r_plen <= (prod == '0) ? PLEN_W'(1) : prod;
    end

    // latch item with saturation
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_kind   <= t_kind'(i_kind);
            r_row    <= i_row;
            r_tick   <= i_tick;
            r_trow   <= i_target_row;
            r_ttick  <= i_target_tick;
            r_slot   <= i_slot;
            r_vel    <= (i_note_velocity == 8'd0) ? VEL_W'(1) :
                        (i_note_velocity > 8'(VEL_MAX)) ? VEL_W'(VEL_MAX) :
                        i_note_velocity[VEL_W-1:0];
            r_chance <= (i_chance > 8'(CHN_MAX)) ? CHN_W'(CHN_MAX) : i_chance[CHN_W-1:0];
            r_len    <= (i_length_ticks == '0) ? LEN_W'(1) : i_length_ticks;
        end
    end

    // search bounds, captured entry, held source
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_src) begin
            r_key_row  <= r_row;
            r_key_tick <= r_tick;
        end else if (i_cmd.init_tgt) begin
            r_key_row  <= r_trow;
            r_key_tick <= r_ttick;
        end
        if (i_cmd.init_src || i_cmd.init_tgt) begin
            r_lo <= '0;
            r_hi <= r_used;
        end else if (i_cmd.srch_cmp) begin
            if (less) begin
                r_lo <= mid + CW'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.rd_lo) begin
            r_pos <= r_lo;
        end else if (i_cmd.rd_slot) begin
            r_pos <= {1'b0, r_slot};
        end else if (i_cmd.wr_new) begin
            r_pos <= r_lo;
        end
        if (i_cmd.cap) begin
            r_ev    <= rd_data;
            r_found <= (r_pos < r_used) && (rd_data.tick == r_key_tick) &&
                       (rd_data.row == r_key_row);
        end else if (i_cmd.wr_new) begin
            r_ev <= new_e;
        end else if (i_cmd.wr_upd) begin
            r_ev <= upd_e;
        end
        if (i_cmd.save_src) begin
            r_src  <= r_pos;
            r_hold <= r_ev;
        end
    end

    // shift engine: one entry read per cycle, written in the next cycle unless trim drops it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_more <= 1'b0;
            r_pend <= 1'b0;
            r_mode <= M_UP;
        end else if (i_cmd.sh_up) begin
            r_mode <= M_UP;
            r_idx  <= r_used - CW'(1);
            r_more <= r_used != r_lo;
            r_pend <= 1'b0;
        end else if (i_cmd.sh_dn) begin
            r_mode <= M_DN;
            r_idx  <= r_src + CW'(1);
            r_more <= (r_src + CW'(1)) < r_used;
            r_pend <= 1'b0;
        end else if (i_cmd.sh_trim) begin
            r_mode <= M_TRIM;
            r_idx  <= '0;
            r_wa   <= '0;
            r_more <= r_used != '0;
            r_pend <= 1'b0;
        end else if (i_cmd.sh_run) begin
            r_pend <= r_more;
            unique case (r_mode)
                M_UP: begin
                    r_wa   <= r_idx + CW'(1);
                    r_idx  <= r_idx - CW'(1);
                    r_more <= r_more && (r_idx != r_lo);
                end
                M_DN: begin
                    r_wa   <= r_idx - CW'(1);
                    r_idx  <= r_idx + CW'(1);
                    r_more <= r_more && (r_idx != r_used - CW'(1));
                end
                default: begin
                    if (r_pend && keep) begin
                        r_wa <= r_wa + CW'(1);
                    end
                    r_idx  <= r_idx + CW'(1);
                    r_more <= r_more && (r_idx != r_used - CW'(1));
                end
            endcase
        end
    end

    // entry count and active flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_active <= 1'b0;
        end else begin
            priority if (i_cmd.used_clr) begin
                r_used <= '0;
            end else if (i_cmd.used_inc) begin
                r_used <= r_used + CW'(1);
            end else if (i_cmd.used_dec) begin
                r_used <= r_used - CW'(1);
            end else if (i_cmd.used_trim) begin
                r_used <= r_wa;
            end
            if (i_cmd.set_active) begin
                r_active <= 1'b1;
            end
        end
    end

    // result registers, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.done;
        end
        if (i_cmd.done) begin
            o_status         <= i_cmd.status;
            o_entry_count    <= r_used;
            o_pattern_active <= r_active;
            if (i_cmd.show) begin
                o_found_slot     <= r_pos[AW-1:0];
                o_event_row      <= r_ev.row;
                o_event_tick     <= r_ev.tick;
                o_event_velocity <= r_ev.vel;
                o_event_chance   <= r_ev.chance;
                o_event_length   <= r_ev.len;
            end else begin
                o_found_slot     <= '0;
                o_event_row      <= '0;
                o_event_tick     <= '0;
                o_event_velocity <= '0;
                o_event_chance   <= '0;
                o_event_length   <= '0;
            end
        end
    end

endmodule

// ===== design/set_ctrl.sv =====
// Controller: sequences search, shift and write steps for each command.
module set_ctrl import set_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DISP   = 14'b00000000000010,
        S_ADDRNG = 14'b00000000000100,
        S_SRCH   = 14'b00000000001000,
        S_SCMP   = 14'b00000000010000,
        S_LCHK   = 14'b00000000100000,
        S_EVAL   = 14'b00000001000000,
        S_MVRNG  = 14'b00000010000000,
        S_DNINIT = 14'b00000100000000,
        S_SHDN   = 14'b00001000000000,
        S_DNEND  = 14'b00010000000000,
        S_SHUP   = 14'b00100000000000,
        S_RDCHK  = 14'b01000000000000,
        S_FIN    = 14'b10000000000000
    } t_state;

    typedef enum logic [1:0] {
        PH_SRC = 2'd0,
        PH_TGT = 2'd1,
        PH_INS = 2'd2
    } t_phase;

    t_state  r_state, n_state;
    t_phase  r_phase, n_phase;
    t_status r_status, n_status;
    logic    r_show, n_show, r_rdcap, n_rdcap;

    assign o_busy = r_state != S_IDLE;

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_status = r_status;
        n_show   = r_show;
        n_rdcap  = r_rdcap;
        o_cmd    = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.ld_in = 1'b1;
                    n_phase  = PH_SRC;
                    n_status = ST_OK;
                    n_show   = 1'b0;
                    n_rdcap  = 1'b0;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.kind)
                    K_ADD: begin
                        o_cmd.init_src = 1'b1;
                        n_state = S_ADDRNG;
                    end
                    K_REMOVE, K_MOVE, K_UPDATE, K_FIND: begin
                        o_cmd.init_src = 1'b1;
                        n_state = S_SRCH;
                    end
                    K_READ: n_state = S_RDCHK;
                    K_CLEAR: begin
                        o_cmd.used_clr = 1'b1;
                        n_state = S_FIN;
                    end
                    default: begin
                        o_cmd.set_active = 1'b1;
                        o_cmd.sh_trim    = 1'b1;
                        n_state = S_SHDN;
                    end
                endcase
            end
            S_ADDRNG: begin
                if (!i_stat.in_range) begin
                    n_status = ST_RANGE;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.set_active = 1'b1;
                    n_state = S_SRCH;
                end
            end
            // lower-bound search, each step a read in S_SRCH and a compare in S_SCMP
            S_SRCH: begin
                if (i_stat.lt) begin
                    o_cmd.srch_rd = 1'b1;
                    n_state = S_SCMP;
                end else begin
                    o_cmd.rd_lo = 1'b1;
                    n_state = S_LCHK;
                end
            end
            S_SCMP: begin
                o_cmd.srch_cmp = 1'b1;
                n_state = S_SRCH;
            end
            S_LCHK: begin
                o_cmd.cap = 1'b1;
                n_state = r_rdcap ? S_FIN : S_EVAL;
            end
            S_EVAL: begin
                unique case (i_stat.kind)
                    K_ADD: begin
                        if (i_stat.found) begin
                            o_cmd.wr_upd = 1'b1;
                            n_show  = 1'b1;
                            n_state = S_FIN;
                        end else if (i_stat.full) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            o_cmd.sh_up = 1'b1;
                            n_state = S_SHUP;
                        end
                    end
                    K_MOVE: begin
                        unique case (r_phase)
                            PH_SRC: begin
                                if (!i_stat.found) begin
                                    n_status = ST_NOT_FOUND;
                                    n_state  = S_FIN;
                                end else begin
                                    o_cmd.save_src = 1'b1;
                                    o_cmd.init_tgt = 1'b1;
                                    n_state = S_MVRNG;
                                end
                            end
                            PH_TGT: begin
                                if (i_stat.found) begin
                                    n_status = ST_TAKEN;
                                    n_state  = S_FIN;
                                end else begin
                                    n_state = S_DNINIT;
                                end
                            end
                            default: begin
                                o_cmd.sh_up = 1'b1;
                                n_state = S_SHUP;
                            end
                        endcase
                    end
                    K_REMOVE: begin
                        if (!i_stat.found) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_FIN;
                        end else begin
                            o_cmd.save_src = 1'b1;
                            n_state = S_DNINIT;
                        end
                    end
                    K_UPDATE: begin
                        if (!i_stat.found) begin
                            n_status = ST_NOT_FOUND;
                        end else begin
                            o_cmd.wr_upd = 1'b1;
                            n_show = 1'b1;
                        end
                        n_state = S_FIN;
                    end
                    default: begin
                        if (!i_stat.found) begin
                            n_status = ST_NOT_FOUND;
                        end else begin
                            n_show = 1'b1;
                        end
                        n_state = S_FIN;
                    end
                endcase
            end
            S_MVRNG: begin
                if (!i_stat.in_range) begin
                    n_status = ST_RANGE;
                    n_state  = S_FIN;
                end else if (i_stat.same_key) begin
                    n_state = S_DNINIT;
                end else begin
                    n_phase = PH_TGT;
                    n_state = S_SRCH;
                end
            end
            S_DNINIT: begin
                o_cmd.sh_dn = 1'b1;
                n_state = S_SHDN;
            end
            // shared by delete shifts and trim compaction
            S_SHDN: begin
                o_cmd.sh_run = 1'b1;
                if (!i_stat.sh_busy) begin
                    if (i_stat.kind == K_TRIM) begin
                        o_cmd.used_trim = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        o_cmd.used_dec = 1'b1;
                        n_state = S_DNEND;
                    end
                end
            end
            S_DNEND: begin
                if (i_stat.kind == K_MOVE) begin
                    o_cmd.init_tgt = 1'b1;
                    n_phase = PH_INS;
                    n_state = S_SRCH;
                end else begin
                    n_show  = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_SHUP: begin
                o_cmd.sh_run = 1'b1;
                if (!i_stat.sh_busy) begin
                    o_cmd.wr_new   = 1'b1;
                    o_cmd.wr_hold  = i_stat.kind == K_MOVE;
                    o_cmd.used_inc = 1'b1;
                    if (i_stat.kind == K_MOVE) begin
                        o_cmd.set_active = 1'b1;
                    end
                    n_show  = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_RDCHK: begin
                if (!i_stat.slot_ok) begin
                    n_status = ST_RANGE;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.rd_slot = 1'b1;
                    n_show  = 1'b1;
                    n_rdcap = 1'b1;
                    n_state = S_LCHK;
                end
            end
            S_FIN: begin
                o_cmd.done = 1'b1;
                o_cmd.show = r_show;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_SRC;
            r_status <= ST_OK;
            r_show   <= 1'b0;
            r_rdcap  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_status <= n_status;
            r_show   <= n_show;
            r_rdcap  <= n_rdcap;
        end
    end

endmodule

// ===== design/sorted_event_table.sv =====
// Top level of the sorted event table: controller plus datapath.
//
// Usage: a command is transferred at a rising edge with start high and busy low;
// busy stays high until its result has been latched. Each command gives exactly
// one result, shown on the o_ ports for one cycle with o_valid high; the receiver
// cannot stall, so it must take the transfer in that cycle.
// Configuration (beats per bar, beat unit, bar count) is written through
// i_cfg_we / i_cfg_idx / i_cfg_data in a single cycle; the user must write it only
// while the table is idle, which the block itself does not enforce.
// The single RAM port pair serializes each command into search steps (at most
// ceil(log2(entries+1)) of them, a read and a compare each) and shift steps:
//   insert or remove: a search, then a shift of each entry from the slot to the end;
//   move: up to three searches, a delete shift and an insert shift;
//   trim: one RAM read per entry.
// One command at a time; the next may be transferred in the cycle o_valid shows.
// The pattern length follows a config write through the config register, then
// r_base, then r_plen.
// Reset (i_rst_n low, synchronous) empties the table, clears the active flag
// and sets the configuration to 4, 4, 1; no clearing pass is needed since the
// contents of slots at or beyond the entry count are never used.
module sorted_event_table import set_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [2:0]            i_kind,
    input  logic [ROW_W-1:0]      i_row,
    input  logic [TICK_W-1:0]     i_tick,
    input  logic [ROW_W-1:0]      i_target_row,
    input  logic [TICK_W-1:0]     i_target_tick,
    input  logic [7:0]            i_note_velocity,
    input  logic [7:0]            i_chance,
    input  logic [LEN_W-1:0]      i_length_ticks,
    input  logic [AW-1:0]         i_slot,
    output logic                  o_valid,
    output logic [2:0]            o_status,
    output logic [AW-1:0]         o_found_slot,
    output logic [ROW_W-1:0]      o_event_row,
    output logic [TICK_W-1:0]     o_event_tick,
    output logic [VEL_W-1:0]      o_event_velocity,
    output logic [CHN_W-1:0]      o_event_chance,
    output logic [LEN_W-1:0]      o_event_length,
    output logic [CW-1:0]         o_entry_count,
    output logic                  o_pattern_active
);

    t_cmd  cmd;
    t_stat stat;

    set_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    set_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_row            (i_row),
        .i_tick           (i_tick),
        .i_target_row     (i_target_row),
        .i_target_tick    (i_target_tick),
        .i_note_velocity  (i_note_velocity),
        .i_chance         (i_chance),
        .i_length_ticks   (i_length_ticks),
        .i_slot           (i_slot),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_found_slot     (o_found_slot),
        .o_event_row      (o_event_row),
        .o_event_tick     (o_event_tick),
        .o_event_velocity (o_event_velocity),
        .o_event_chance   (o_event_chance),
        .o_event_length   (o_event_length),
        .o_entry_count    (o_entry_count),
        .o_pattern_active (o_pattern_active)
    );

endmodule

// ===== design/set_checker.sv =====
// Port-level checker for the sorted event table, bound to the top level.
`include "assert_macros.svh"

module set_checker import set_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic [2:0]            o_status,
    input logic [AW-1:0]         o_found_slot,
    input logic [ROW_W-1:0]      o_event_row,
    input logic [TICK_W-1:0]     o_event_tick,
    input logic [CW-1:0]         o_entry_count
);

    // a transfer always makes the block busy
    `SET_ASSERT_NXT(a_start_busy, start && !busy, busy)
    // a result is shown only at the end of a command, for one cycle
    `SET_ASSERT_NXT(a_single_strobe, o_valid, !o_valid)
    `SET_ASSERT_IMP(a_result_ends_cmd, o_valid, $past(busy))
    // failed commands return no event
    `SET_ASSERT_IMP(a_fail_zero, o_valid && o_status != ST_OK,
                    o_found_slot == '0 && o_event_row == '0 && o_event_tick == '0)
    // count never exceeds the table size
    `SET_ASSERT_IMP(a_count_max, o_valid, o_entry_count <= CW'(MAX_EVENTS))

endmodule

bind sorted_event_table set_checker u_set_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sorted event table: directed table plus random commands.
`timescale 1ns / 100ps

module tb_top;
    import set_pkg::*;

    // One command as driven on the input ports
    typedef struct {
        t_kind        kind;
        logic [7:0]   row;
        logic [18:0]  tick;
        logic [7:0]   trow;
        logic [18:0]  ttick;
        logic [7:0]   vel;
        logic [7:0]   chance;
        logic [15:0]  len;
        logic [7:0]   slot;
    } t_req;

    // One result as seen on the output ports
    typedef struct {
        t_status      status;
        logic [7:0]   slot;
        logic [7:0]   row;
        logic [18:0]  tick;
        logic [6:0]   vel;
        logic [6:0]   chance;
        logic [15:0]  len;
        logic [8:0]   count;
        logic         active;
    } t_resp;

    // Directed row: command plus optional hand-typed outcome
    typedef struct {
        t_req         req;
        bit           typed;
        t_status      status;
        int           count;
        bit           active;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic [2:0]            i_kind = '0;
    logic [ROW_W-1:0]      i_row = '0;
    logic [TICK_W-1:0]     i_tick = '0;
    logic [ROW_W-1:0]      i_target_row = '0;
    logic [TICK_W-1:0]     i_target_tick = '0;
    logic [7:0]            i_note_velocity = '0;
    logic [7:0]            i_chance = '0;
    logic [LEN_W-1:0]      i_length_ticks = '0;
    logic [AW-1:0]         i_slot = '0;
    logic                  o_valid;
    logic [2:0]            o_status;
    logic [AW-1:0]         o_found_slot;
    logic [ROW_W-1:0]      o_event_row;
    logic [TICK_W-1:0]     o_event_tick;
    logic [VEL_W-1:0]      o_event_velocity;
    logic [CHN_W-1:0]      o_event_chance;
    logic [LEN_W-1:0]      o_event_length;
    logic [CW-1:0]         o_entry_count;
    logic                  o_pattern_active;

    sorted_event_table u_dut (.*);

    always #2 i_clk = ~i_clk;

    // Mirror of the table state and registers
    t_entry     table_mirror [MAX_EVENTS];
    int         mirror_used;
    bit         mirror_active;
    int         reg_beats, reg_unit, reg_bars;

    t_resp      pending_results[$];
    t_dir_row   directed_rows[$];
    int         error_count = 0;
    bit         no_idle = 1'b0;

    function automatic int pattern_len();
        int num, den, bars, l;
        num  = reg_beats < 1 ? 1 : (reg_beats > BEATS_MAX ? BEATS_MAX : reg_beats);
        bars = reg_bars < 1 ? 1 : (reg_bars > BARS_MAX ? BARS_MAX : reg_bars);
        den  = (reg_unit == 2 || reg_unit == 4 || reg_unit == 8 || reg_unit == 16) ?
               reg_unit : 4;
        l = TICKS_PER_QUARTER * num * 4 / den * bars;
        return l < 1 ? 1 : l;
    endfunction

    // Binary search: first slot whose (tick,row) key is not below the given key
    function automatic int key_floor(int row, int tick);
        int lo, hi, mid;
        lo = 0;
        hi = mirror_used;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (table_mirror[mid].tick < tick ||
                (table_mirror[mid].tick == tick && table_mirror[mid].row < row))
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic int slot_of(int row, int tick);
        int p;
        p = key_floor(row, tick);
        if (p < mirror_used && table_mirror[p].tick == tick && table_mirror[p].row == row)
            return p;
        return -1;
    endfunction

    function automatic void drop_slot(int p);
        for (int i = p; i + 1 < mirror_used; i++)
            table_mirror[i] = table_mirror[i+1];
        mirror_used--;
        table_mirror[mirror_used] = '0;
    endfunction

    function automatic int place_entry(t_entry e);
        int p;
        p = key_floor(e.row, e.tick);
        for (int i = mirror_used; i > p; i--)
            table_mirror[i] = table_mirror[i-1];
        table_mirror[p] = e;
        mirror_used++;
        return p;
    endfunction

    // Applies one command to the mirror and returns the result it produces
    function automatic t_resp apply_command(t_req r);
        t_resp  res;
        t_entry e;
        int     p, w, l;
        bit     show;
        int     vel, chn, dur;
        res = '{ST_OK, 0, 0, 0, 0, 0, 0, 0, 0};
        show = 1'b0;
        p = 0;
        e = '0;
        vel = r.vel < 1 ? 1 : (r.vel > VEL_MAX ? VEL_MAX : r.vel);
        chn = r.chance > CHN_MAX ? CHN_MAX : r.chance;
        dur = r.len < 1 ? 1 : r.len;
        case (r.kind)
            K_ADD: begin
                if (r.row >= ROW_COUNT || r.tick >= pattern_len()) begin
                    res.status = ST_RANGE;
                end else begin
                    mirror_active = 1'b1;
                    p = slot_of(r.row, r.tick);
                    if (p >= 0) begin
                        table_mirror[p].vel = VEL_W'(vel);
                        table_mirror[p].chance = CHN_W'(chn);
                        table_mirror[p].len = LEN_W'(dur);
                        show = 1'b1;
                    end else if (mirror_used >= MAX_EVENTS) begin
                        res.status = ST_FULL;
                    end else begin
                        e.tick = r.tick; e.row = r.row; e.vel = VEL_W'(vel);
                        e.chance = CHN_W'(chn); e.len = LEN_W'(dur);
                        p = place_entry(e);
                        show = 1'b1;
                    end
                end
            end
            K_REMOVE: begin
                p = slot_of(r.row, r.tick);
                if (p < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    e = table_mirror[p];
                    drop_slot(p);
                    res.slot = 8'(p); res.row = e.row; res.tick = e.tick;
                    res.vel = e.vel; res.chance = e.chance; res.len = e.len;
                end
            end
            K_MOVE: begin
                p = slot_of(r.row, r.tick);
                if (p < 0)
                    res.status = ST_NOT_FOUND;
                else if (r.trow >= ROW_COUNT || r.ttick >= pattern_len())
                    res.status = ST_RANGE;
                else if ((r.trow != r.row || r.ttick != r.tick) &&
                         slot_of(r.trow, r.ttick) >= 0)
                    res.status = ST_TAKEN;
                else begin
                    e = table_mirror[p];
                    drop_slot(p);
                    e.row = r.trow;
                    e.tick = r.ttick;
                    mirror_active = 1'b1;
                    p = place_entry(e);
                    show = 1'b1;
                end
            end
            K_UPDATE: begin
                p = slot_of(r.row, r.tick);
                if (p < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    table_mirror[p].vel = VEL_W'(vel);
                    table_mirror[p].chance = CHN_W'(chn);
                    table_mirror[p].len = LEN_W'(dur);
                    show = 1'b1;
                end
            end
            K_FIND: begin
                p = slot_of(r.row, r.tick);
                if (p < 0) res.status = ST_NOT_FOUND;
                else show = 1'b1;
            end
            K_READ: begin
                if (r.slot >= mirror_used) begin
                    res.status = ST_RANGE;
                end else begin
                    p = r.slot;
                    show = 1'b1;
                end
            end
            K_CLEAR: begin
                foreach (table_mirror[i]) table_mirror[i] = '0;
                mirror_used = 0;
            end
            default: begin
                // trim: compact entries that fall inside the pattern
                l = pattern_len();
                mirror_active = 1'b1;
                w = 0;
                for (int i = 0; i < mirror_used; i++) begin
                    if (table_mirror[i].tick < l) begin
                        table_mirror[w] = table_mirror[i];
                        w++;
                    end
                end
                for (int i = w; i < mirror_used; i++) table_mirror[i] = '0;
                mirror_used = w;
            end
        endcase
        if (show) begin
            e = table_mirror[p];
            res.slot = 8'(p); res.row = e.row; res.tick = e.tick;
            res.vel = e.vel; res.chance = e.chance; res.len = e.len;
        end
        res.count = 9'(mirror_used);
        res.active = mirror_active;
        return res;
    endfunction

    // Drive one command, wait for its transfer, queue its result
    task automatic issue(t_req r, bit typed, t_resp typed_res);
        t_resp res;
        i_kind <= r.kind;          i_row <= r.row;            i_tick <= r.tick;
        i_target_row <= r.trow;    i_target_tick <= r.ttick;  i_note_velocity <= r.vel;
        i_chance <= r.chance;      i_length_ticks <= r.len;   i_slot <= r.slot;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        res = apply_command(r);
        pending_results.push_back(typed ? typed_res : res);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BEATS: reg_beats = value & 6'h3f;
            CFG_UNIT:  reg_unit  = value & 5'h1f;
            CFG_BARS:  reg_bars  = value & 7'h7f;
            default: ;
        endcase
        repeat (3) @(posedge i_clk);
    endtask

    task automatic dir(t_kind k, int row, int tick, int trow, int ttick, int vel, int ch,
                       int len, int slot, bit typed = 0, t_status st = ST_OK,
                       int cnt = 0, bit act = 0);
        t_dir_row d;
        d.req = '{k, row, tick, trow, ttick, vel, ch, len, slot};
        d.typed = typed;
        d.status = st;
        d.count = cnt;
        d.active = act;
        directed_rows.push_back(d);
    endtask

    function automatic logic [18:0] pick_tick();
        int l;
        l = pattern_len();
        case ($urandom_range(0, 9))
            0:       return 19'($urandom_range(0, 19'h7ffff));
            1, 2:    return 19'(l - 1);
            3, 4, 5: return 19'($urandom_range(0, 15) * (l / 16));
            default: return 19'($urandom_range(0, l - 1));
        endcase
    endfunction

    function automatic t_req random_command();
        t_req r;
        int   k, p;
        k = $urandom_range(0, 99);
        r.kind = k < 35 ? K_ADD : k < 50 ? K_REMOVE : k < 62 ? K_MOVE : k < 72 ? K_UPDATE :
                 k < 82 ? K_FIND : k < 92 ? K_READ : k < 94 ? K_CLEAR : K_TRIM;
        r.row = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 127);
        r.tick = pick_tick();
        // aim at stored events most of the time
        if (r.kind != K_ADD && mirror_used > 0 && $urandom_range(0, 9) < 7) begin
            p = $urandom_range(0, mirror_used - 1);
            r.row = table_mirror[p].row;
            r.tick = table_mirror[p].tick;
        end
        r.trow = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 127);
        r.ttick = pick_tick();
        if (mirror_used > 0 && $urandom_range(0, 4) == 0) begin
            p = $urandom_range(0, mirror_used - 1);
            r.trow = table_mirror[p].row;
            r.ttick = table_mirror[p].tick;
        end
        r.vel = $urandom_range(0, 255);
        r.chance = $urandom_range(0, 255);
        r.len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : $urandom_range(0, 65535);
        r.slot = $urandom_range(0, 1) ? $urandom_range(0, 255) :
                 $urandom_range(0, mirror_used > 0 ? mirror_used : 0);
        return r;
    endfunction

    // Result checker: one result per o_valid, against the oldest expectation
    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d", $time, o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status != want.status || o_found_slot != want.slot ||
                    o_event_row != want.row || o_event_tick != want.tick ||
                    o_event_velocity != want.vel || o_event_chance != want.chance ||
                    o_event_length != want.len || o_entry_count != want.count ||
                    o_pattern_active != want.active) begin
                    $display("%0t: mismatch expected st=%0d slot=%0d row=%0d tick=%0d vel=%0d ch=%0d len=%0d cnt=%0d act=%0d",
                             $time, want.status, want.slot, want.row, want.tick, want.vel,
                             want.chance, want.len, want.count, want.active);
                    $display("%0t:          actual   st=%0d slot=%0d row=%0d tick=%0d vel=%0d ch=%0d len=%0d cnt=%0d act=%0d",
                             $time, o_status, o_found_slot, o_event_row, o_event_tick,
                             o_event_velocity, o_event_chance, o_event_length,
                             o_entry_count, o_pattern_active);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    // Main sequence
    initial begin
        t_resp  typed_res;
        t_req   r;
        int     cfg_sets [6][3];

        foreach (table_mirror[i]) table_mirror[i] = '0;
        mirror_used = 0;
        mirror_active = 1'b0;
        reg_beats = 4;
        reg_unit = 4;
        reg_bars = 1;
        cfg_sets = '{'{32, 2, 64}, '{0, 1, 0}, '{63, 31, 127}, '{3, 8, 2},
                     '{7, 16, 5}, '{4, 4, 1}};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, range limits, saturation, move cases (pattern 384 ticks)
        dir(K_FIND,   0, 0, 0, 0, 0, 0, 0, 0,   1, ST_NOT_FOUND, 0, 0);
        dir(K_READ,   0, 0, 0, 0, 0, 0, 0, 0,   1, ST_RANGE, 0, 0);
        dir(K_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0,   1, ST_NOT_FOUND, 0, 0);
        dir(K_ADD,    128, 0, 0, 0, 1, 1, 1, 0, 1, ST_RANGE, 0, 0);
        dir(K_ADD,    0, 384, 0, 0, 1, 1, 1, 0, 1, ST_RANGE, 0, 0);
        dir(K_ADD,    0, 0, 0, 0, 0, 0, 0, 0);
        dir(K_ADD,    127, 383, 0, 0, 255, 255, 65535, 0);
        dir(K_ADD,    5, 100, 0, 0, 128, 101, 1, 0);
        dir(K_ADD,    5, 100, 0, 0, 1, 100, 2, 0);
        dir(K_FIND,   5, 100, 0, 0, 0, 0, 0, 0);
        dir(K_UPDATE, 127, 383, 0, 0, 127, 0, 0, 0);
        dir(K_UPDATE, 3, 3, 0, 0, 9, 9, 9, 0,   1, ST_NOT_FOUND, 3, 1);
        dir(K_MOVE,   5, 100, 0, 0, 0, 0, 0, 0,   1, ST_TAKEN, 3, 1);
        dir(K_MOVE,   5, 100, 200, 0, 0, 0, 0, 0, 1, ST_RANGE, 3, 1);
        dir(K_MOVE,   5, 100, 5, 384, 0, 0, 0, 0, 1, ST_RANGE, 3, 1);
        dir(K_MOVE,   9, 9, 1, 1, 0, 0, 0, 0,   1, ST_NOT_FOUND, 3, 1);
        dir(K_MOVE,   5, 100, 5, 100, 0, 0, 0, 0);
        dir(K_MOVE,   5, 100, 64, 50, 0, 0, 0, 0);
        dir(K_READ,   0, 0, 0, 0, 0, 0, 0, 0);
        dir(K_READ,   0, 0, 0, 0, 0, 0, 0, 2);
        dir(K_READ,   0, 0, 0, 0, 0, 0, 0, 255, 1, ST_RANGE, 3, 1);
        dir(K_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0);
        dir(K_TRIM,   0, 0, 0, 0, 0, 0, 0, 0);
        dir(K_CLEAR,  0, 0, 0, 0, 0, 0, 0, 0);
        foreach (directed_rows[i]) begin
            typed_res = '{directed_rows[i].req.kind == K_ADD ? ST_OK : ST_OK,
                          0, 0, 0, 0, 0, 0, 0, 0};
            typed_res.status = directed_rows[i].status;
            typed_res.count = 9'(directed_rows[i].count);
            typed_res.active = directed_rows[i].active;
            issue(directed_rows[i].req, directed_rows[i].typed, typed_res);
        end
        wait_idle();

        // Fill the table to capacity, then probe full-table behavior
        for (int i = 0; i < MAX_EVENTS + 1; i++) begin
            r = '{K_ADD, (i * 37) % ROW_COUNT, (i * 97) % 384, 0, 0,
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 65535), 0};
            issue(r, 1'b0, typed_res);
        end
        for (int i = 0; i < 12; i++) issue(random_command(), 1'b0, typed_res);

        // Random phases under different time signatures; shrinking lengths make trim bite
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            write_reg(CFG_BEATS, cfg_sets[ph][0]);
            write_reg(CFG_UNIT,  cfg_sets[ph][1]);
            write_reg(CFG_BARS,  cfg_sets[ph][2]);
            if (ph == 3) write_reg(CFG_NONE, 7'h7f);
            no_idle = (ph == 5);
            for (int n = 0; n < 26; n++) issue(random_command(), 1'b0, typed_res);
        end

        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/set_pkg.sv
design/set_ram.sv
design/set_dpath.sv
design/set_ctrl.sv
design/sorted_event_table.sv
design/set_checker.sv
tb/tb_top.sv
